[src/lsps_pkg.sv]
// ----------------------------------------------------------------------------
// lsps_pkg
// Types, codes and the status pattern table for the LED status sequencer.
// ----------------------------------------------------------------------------
package lsps_pkg;

    // Time arithmetic wraps at this width.
    localparam int TIME_WIDTH   = 32;
    // An active time equal to this value keeps the window open forever.
    localparam int FOREVER_TIME = 255;

    localparam int ACTIVE_W = 8;
    localparam int PERIOD_W = 5;

    typedef logic [TIME_WIDTH-1:0] time_t;

    // Status codes; a lower code has higher priority.
    localparam logic [3:0] ST_POWER_LOW   = 4'd0;
    localparam logic [3:0] ST_CHARGING    = 4'd1;
    localparam logic [3:0] ST_CHARGE_DONE = 4'd2;
    localparam logic [3:0] ST_XFER_ERROR  = 4'd3;
    localparam logic [3:0] ST_XFERRING    = 4'd4;
    localparam logic [3:0] ST_CONNECTED   = 4'd5;
    localparam logic [3:0] ST_DATA_FULL   = 4'd6;
    localparam logic [3:0] ST_BEGIN       = 4'd7;
    localparam logic [3:0] ST_END         = 4'd8;
    localparam logic [3:0] ST_IDLE        = 4'd9;

    // Commands.
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Flash modes.
    localparam logic [2:0] MODE_1HZ    = 3'd0;
    localparam logic [2:0] MODE_BREATH = 3'd1;
    localparam logic [2:0] MODE_FAST   = 3'd2;
    localparam logic [2:0] MODE_ON     = 3'd3;
    localparam logic [2:0] MODE_OFF    = 3'd4;

    // LED choice.
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BOTH  = 2'd2;

    // Breathing selection.
    localparam logic [1:0] BREATH_STOP  = 2'd0;
    localparam logic [1:0] BREATH_RED   = 2'd1;
    localparam logic [1:0] BREATH_GREEN = 2'd2;

    typedef struct packed {
        logic        command;
        logic [3:0]  status_code;
        logic [31:0] now_seconds;
    } cmd_item_t;

    typedef struct packed {
        logic       request_taken;
        logic       red_on;
        logic       green_on;
        logic [1:0] breath_select;
    } res_item_t;

    typedef struct packed {
        logic [3:0] current_status;
        time_t      window_start;
        time_t      last_toggle_second;
        logic       alternate_phase;
        logic       red_lit;
        logic       green_lit;
        logic [1:0] breath_state;
    } state_t;

    typedef struct packed {
        logic [2:0]          mode;
        logic [ACTIVE_W-1:0] active;
        logic [1:0]          leds;
        logic [PERIOD_W-1:0] period;
    } pattern_t;

    // Fixed pattern for each status; unknown codes behave as idle.
    function automatic pattern_t pattern_lookup(input logic [3:0] code);
        pattern_t p;
        case (code)
            ST_POWER_LOW:   p = '{MODE_1HZ,    ACTIVE_W'(8'hff),         SEL_RED,   5'd0};
            ST_CHARGING:    p = '{MODE_BREATH, ACTIVE_W'(FOREVER_TIME),  SEL_GREEN, 5'd0};
            ST_CHARGE_DONE: p = '{MODE_ON,     ACTIVE_W'(FOREVER_TIME),  SEL_GREEN, 5'd0};
            ST_XFER_ERROR:  p = '{MODE_FAST,   ACTIVE_W'(5),             SEL_RED,   5'd0};
            ST_XFERRING:    p = '{MODE_FAST,   ACTIVE_W'(FOREVER_TIME),  SEL_GREEN, 5'd0};
            ST_CONNECTED:   p = '{MODE_ON,     ACTIVE_W'(5),             SEL_RED,   5'd0};
            ST_DATA_FULL:   p = '{MODE_1HZ,    ACTIVE_W'(10),            SEL_BOTH,  5'd30};
            ST_BEGIN:       p = '{MODE_1HZ,    ACTIVE_W'(10),            SEL_GREEN, 5'd0};
            ST_END:         p = '{MODE_1HZ,    ACTIVE_W'(10),            SEL_RED,   5'd0};
            default:        p = '{MODE_OFF,    ACTIVE_W'(0),             SEL_BOTH,  5'd0};
        endcase
        return p;
    endfunction

endpackage

[src/lsps_if.sv]
// ----------------------------------------------------------------------------
// lsps_cmd_if / lsps_res_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lsps_cmd_if;
    logic                valid;
    logic                ready;
    lsps_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lsps_res_if;
    logic                valid;
    logic                ready;
    lsps_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/lsps_step.sv]
// ----------------------------------------------------------------------------
// lsps_step
// Next-state and result logic for one command item.
// ----------------------------------------------------------------------------
module lsps_step (
    input  lsps_pkg::state_t    state,
    input  lsps_pkg::cmd_item_t item,
    output lsps_pkg::state_t    state_next,
    output lsps_pkg::res_item_t result
);
    import lsps_pkg::*;

    pattern_t pat;
    time_t    now_t;
    time_t    win_end;
    time_t    win_again;
    logic     win_open;
    logic     taken;
    logic     tog_red;
    logic     tog_green;
    logic     tog_phase;

    // Pattern of the current status and the window bounds.
    always_comb
    begin
        pat       = pattern_lookup(state.current_status);
        now_t     = TIME_WIDTH'(item.now_seconds);
        win_end   = state.window_start + TIME_WIDTH'(pat.active);
        win_again = state.window_start + TIME_WIDTH'(pat.period);
        win_open  = (pat.active == ACTIVE_W'(FOREVER_TIME)) || (now_t < win_end);
    end

    // LED values after one toggle step; with both LEDs selected they alternate by phase.
    always_comb
    begin
        tog_red   = state.red_lit;
        tog_green = state.green_lit;
        tog_phase = state.alternate_phase;
        case (pat.leds)
            SEL_RED:
            begin
                tog_green = 1'b0;
                tog_red   = ~state.red_lit;
            end
            SEL_GREEN:
            begin
                tog_red   = 1'b0;
                tog_green = ~state.green_lit;
            end
            default:
            begin
                tog_red   = ~state.alternate_phase;
                tog_green = state.alternate_phase;
                tog_phase = ~state.alternate_phase;
            end
        endcase
    end

    // Request arbitration and tick handling.
    always_comb
    begin
        state_next = state;
        taken      = 1'b0;
        if (item.command == CMD_REQUEST)
        begin
            if ((item.status_code < state.current_status) || (item.status_code == ST_IDLE))
            begin
                state_next.current_status = item.status_code;
                state_next.window_start   = now_t;
                taken                     = 1'b1;
            end
        end
        else if (win_open)
        begin
            case (pat.mode)
                MODE_1HZ:
                begin
                    state_next.breath_state = BREATH_STOP;
                    if (state.last_toggle_second != now_t)
                    begin
                        state_next.last_toggle_second = now_t;
                        state_next.red_lit            = tog_red;
                        state_next.green_lit          = tog_green;
                        state_next.alternate_phase    = tog_phase;
                    end
                end
                MODE_BREATH:
                begin
                    if (pat.leds == SEL_RED)
                    begin
                        state_next.breath_state = BREATH_RED;
                    end
                    else if (pat.leds == SEL_GREEN)
                    begin
                        state_next.breath_state = BREATH_GREEN;
                    end
                end
                MODE_FAST:
                begin
                    state_next.breath_state    = BREATH_STOP;
                    state_next.red_lit         = tog_red;
                    state_next.green_lit       = tog_green;
                    state_next.alternate_phase = tog_phase;
                end
                MODE_ON:
                begin
                    state_next.breath_state = BREATH_STOP;
                    state_next.red_lit      = (pat.leds != SEL_GREEN);
                    state_next.green_lit    = (pat.leds != SEL_RED);
                end
                default:
                begin
                    state_next.breath_state = BREATH_STOP;
                    state_next.red_lit      = 1'b0;
                    state_next.green_lit    = 1'b0;
                end
            endcase
        end
        else
        begin
            // Window closed: LEDs dark, restart once the period has passed.
            if (now_t > win_again)
            begin
                state_next.window_start = now_t;
            end
            state_next.breath_state = BREATH_STOP;
            state_next.red_lit      = 1'b0;
            state_next.green_lit    = 1'b0;
        end

        result.request_taken = taken;
        result.red_on        = state_next.red_lit;
        result.green_on      = state_next.green_lit;
        result.breath_select = state_next.breath_state;
    end

endmodule

[src/led_status_pattern_sequencer.sv]
// ----------------------------------------------------------------------------
// led_status_pattern_sequencer
// Two-LED status indicator driven by status requests and refresh ticks.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries requests: command 0 asks for a status (lower code wins,
//   idle is always taken), command 1 is a refresh tick that advances the
//   flash pattern at time now_seconds. Every request yields one result on
//   res_ch: whether a status request was taken, the two LED states and the
//   breathing selection.
//   A request is held in an input register, then the pattern logic updates
//   the state and loads the result register when that register is free
//   or draining. One request is taken every cycle while res_ch does not
//   stall; the state update is a single compare-and-select step.
//   When res_ch stalls, the result register holds and at most one further
//   request waits in the input register; cmd_ch.ready drops only then.
//   Reset puts the block in the idle status with both LEDs off, breathing
//   stopped and all time marks at zero.
// ----------------------------------------------------------------------------
module led_status_pattern_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    lsps_cmd_if.sink   cmd_ch,
    lsps_res_if.source res_ch
);
    import lsps_pkg::*;

    logic      in_valid_reg;
    cmd_item_t in_item_reg;
    logic      res_valid_reg;
    res_item_t res_item_reg;
    state_t    state_reg;
    state_t    state_next;
    res_item_t res_next;
    logic      advance;

    // The compute stage moves when the result register is free or draining.
    assign advance      = !res_valid_reg || res_ch.ready;
    assign cmd_ch.ready = !in_valid_reg || advance;

    lsps_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ch.ready)
        begin
            in_valid_reg <= cmd_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.ready && cmd_ch.valid)
        begin
            in_item_reg <= cmd_ch.data;
        end
    end

    // Sequencer state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{ST_IDLE, '0, '0, 1'b0, 1'b0, 1'b0, BREATH_STOP};
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_item_reg <= res_next;
        end
    end

    assign res_ch.valid = res_valid_reg;
    assign res_ch.data  = res_item_reg;

    // The status never leaves the table range.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.current_status <= ST_IDLE)
        else $error("current status out of range");

    // The patterns never light both LEDs at once.
    a_leds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.red_lit && state_reg.green_lit))
        else $error("both LEDs lit");

    // A taken request restarts the window at its own time.
    a_taken_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && res_next.request_taken)
        |=> (state_reg.window_start == $past(TIME_WIDTH'(in_item_reg.now_seconds))))
        else $error("window not restarted on taken request");

    // A tick never reports a taken request.
    a_tick_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && (in_item_reg.command == CMD_TICK))
        |=> !res_item_reg.request_taken)
        else $error("tick reported as taken request");

endmodule
